// ===== hw/rtl/wsp_pkg.sv =====
// Shared widths, register codes and the sideband type for the
// world-to-screen projection pipeline. No dependencies.
package wsp_pkg;

	localparam int COORD_W    = 32;
	localparam int CLIP_W     = 50;
	localparam int QUO_W      = 47;
	localparam int DIV_STAGES = QUO_W;
	localparam int NDC_W      = QUO_W + 1;
	localparam int DIM_W      = 14;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LO   = 3'd0,
		REG_X_HI   = 3'd1,
		REG_Y_LO   = 3'd2,
		REG_Y_HI   = 3'd3,
		REG_W_LO   = 3'd4,
		REG_W_HI   = 3'd5,
		REG_WIDTH  = 3'd6,
		REG_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic ok;
		logic neg_x;
		logic neg_y;
	} wsp_tag_t;

endpackage

// ===== hw/rtl/wsp_clip.sv =====
// Clip-space front end: 3x3 products, row sums, sign/magnitude prep.
// Depends on wsp_pkg.
module wsp_clip (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_x,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_y,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_z,
	input  logic [wsp_pkg::CFG_W-1:0]       row_lo [3],
	input  logic [wsp_pkg::CFG_W-1:0]       row_hi [3],
	input  logic [wsp_pkg::DIM_W-1:0]       width,
	input  logic [wsp_pkg::DIM_W-1:0]       height,
	output wsp_pkg::wsp_tag_t               tag_s3,
	output logic [wsp_pkg::CLIP_W-1:0]      mag_x_s3,
	output logic [wsp_pkg::CLIP_W-1:0]      mag_y_s3,
	output logic [wsp_pkg::CLIP_W-1:0]      den_s3
);
	import wsp_pkg::*;

	logic signed [COORD_W-1:0] coef [3][3];
	logic signed [COORD_W-1:0] world [3];
	logic signed [63:0]        prod_s1 [3][3];
	logic signed [COORD_W-1:0] trans_s1 [3];
	logic                      v_s1;
	logic signed [CLIP_W-1:0]  sum_s2 [3];
	logic                      v_s2;
	logic signed [CLIP_W-1:0]  sum_c [3];
	logic signed [63:0]        sh;
	logic signed [CLIP_W-1:0]  cw;

	always_comb begin
		world[0] = world_x;
		world[1] = world_y;
		world[2] = world_z;
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = row_lo[r][31:0];
			coef[r][1] = row_lo[r][63:32];
			coef[r][2] = row_hi[r][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			tag_s3 <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			tag_s3.valid <= v_s2;
			tag_s3.ok <= !cw[CLIP_W-1] && (cw != '0) && (width != '0) && (height != '0);
			tag_s3.neg_x <= sum_s2[0][CLIP_W-1];
			tag_s3.neg_y <= sum_s2[1][CLIP_W-1];
		end
	end

	// products are floored to 16 fractional bits before the add
	always_comb begin
		sh = '0;
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = CLIP_W'(trans_s1[r]);
			for (int c = 0; c < 3; c++) begin
				sh = prod_s1[r][c] >>> FRAC_W;
				sum_c[r] = sum_c[r] + sh[CLIP_W-1:0];
			end
		end
	end

	assign cw = sum_s2[2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				trans_s1[r] <= row_hi[r][63:32];
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= 64'(coef[r][c]) * 64'(world[c]);
				sum_s2[r] <= sum_c[r];
			end
			mag_x_s3 <= sum_s2[0][CLIP_W-1] ? -sum_s2[0] : sum_s2[0];
			mag_y_s3 <= sum_s2[1][CLIP_W-1] ? -sum_s2[1] : sum_s2[1];
			den_s3 <= cw;
		end
	end

endmodule

// ===== hw/rtl/wsp_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage,
// shared denominator; yields min(floor(mag * 2^16 / den), 2^47). Uses wsp_pkg.
module wsp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  wsp_pkg::wsp_tag_t           tag_in,
	input  logic [wsp_pkg::CLIP_W-1:0]  mag_x,
	input  logic [wsp_pkg::CLIP_W-1:0]  mag_y,
	input  logic [wsp_pkg::CLIP_W-1:0]  den,
	output wsp_pkg::wsp_tag_t           tag_out,
	output logic [wsp_pkg::NDC_W-1:0]   q_x,
	output logic [wsp_pkg::NDC_W-1:0]   q_y
);
	import wsp_pkg::*;

	localparam int LOW_W = CLIP_W - 19;

	wsp_tag_t           tag_sk [DIV_STAGES];
	logic [CLIP_W-1:0]  den_sk [DIV_STAGES];
	logic [CLIP_W-1:0]  rem_sk [DIV_STAGES][2];
	logic [LOW_W-1:0]   low_sk [DIV_STAGES][2];
	logic [QUO_W-1:0]   quo_sk [DIV_STAGES][2];
	logic               sat_sk [DIV_STAGES][2];

	wsp_tag_t           tag_c [DIV_STAGES];
	logic [CLIP_W-1:0]  den_c [DIV_STAGES];
	logic [CLIP_W-1:0]  rem_c [DIV_STAGES][2];
	logic [LOW_W-1:0]   low_c [DIV_STAGES][2];
	logic [QUO_W-1:0]   quo_c [DIV_STAGES][2];
	logic               sat_c [DIV_STAGES][2];
	logic [CLIP_W:0]    trial_c [DIV_STAGES][2];
	logic               ge_c [DIV_STAGES][2];
	logic [CLIP_W-1:0]  mag [2];

	assign mag[0] = mag_x;
	assign mag[1] = mag_y;

	// stage inputs: stage 0 seeds from the ports, the rest from the prior stage
	always_comb begin
		for (int j = 0; j < DIV_STAGES; j++) begin
			tag_c[j] = (j == 0) ? tag_in : tag_sk[(j == 0) ? 0 : j-1];
			den_c[j] = (j == 0) ? den : den_sk[(j == 0) ? 0 : j-1];
			for (int l = 0; l < 2; l++) begin
				if (j == 0) begin
					rem_c[j][l] = CLIP_W'(mag[l][CLIP_W-1:LOW_W]);
					low_c[j][l] = mag[l][LOW_W-1:0];
					quo_c[j][l] = '0;
					sat_c[j][l] = (CLIP_W'(mag[l][CLIP_W-1:LOW_W]) >= den);
				end else begin
					rem_c[j][l] = rem_sk[(j == 0) ? 0 : j-1][l];
					low_c[j][l] = low_sk[(j == 0) ? 0 : j-1][l];
					quo_c[j][l] = quo_sk[(j == 0) ? 0 : j-1][l];
					sat_c[j][l] = sat_sk[(j == 0) ? 0 : j-1][l];
				end
				trial_c[j][l] = {rem_c[j][l], low_c[j][l][LOW_W-1]};
				ge_c[j][l] = (trial_c[j][l] >= {1'b0, den_c[j]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_STAGES; j++)
				tag_sk[j] <= '0;
		end else if (en) begin
			for (int j = 0; j < DIV_STAGES; j++)
				tag_sk[j] <= tag_c[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STAGES; j++) begin
				den_sk[j] <= den_c[j];
				for (int l = 0; l < 2; l++) begin
					rem_sk[j][l] <= ge_c[j][l] ? CLIP_W'(trial_c[j][l] - {1'b0, den_c[j]})
						: trial_c[j][l][CLIP_W-1:0];
					low_sk[j][l] <= {low_c[j][l][LOW_W-2:0], 1'b0};
					quo_sk[j][l] <= {quo_c[j][l][QUO_W-2:0], ge_c[j][l]};
					sat_sk[j][l] <= sat_c[j][l];
				end
			end
		end
	end

	assign tag_out = tag_sk[DIV_STAGES-1];
	assign q_x = sat_sk[DIV_STAGES-1][0] ? {1'b1, {QUO_W{1'b0}}}
		: {1'b0, quo_sk[DIV_STAGES-1][0]};
	assign q_y = sat_sk[DIV_STAGES-1][1] ? {1'b1, {QUO_W{1'b0}}}
		: {1'b0, quo_sk[DIV_STAGES-1][1]};

endmodule

// ===== hw/rtl/wsp_screen.sv =====
// Viewport mapping: NDC to pixel scale, saturation and visibility test.
// Depends on wsp_pkg.
module wsp_screen (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  wsp_pkg::wsp_tag_t                 tag_in,
	input  logic [wsp_pkg::NDC_W-1:0]         q_x,
	input  logic [wsp_pkg::NDC_W-1:0]         q_y,
	input  logic [wsp_pkg::DIM_W-1:0]         width,
	input  logic [wsp_pkg::DIM_W-1:0]         height,
	output logic                              out_valid,
	output logic                              projected,
	output logic signed [wsp_pkg::COORD_W-1:0] screen_x,
	output logic signed [wsp_pkg::COORD_W-1:0] screen_y,
	output logic                              visible
);
	import wsp_pkg::*;

	localparam logic signed [NDC_W:0] ONE = (NDC_W+1)'(65536);
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	logic signed [NDC_W:0]   nx, ny;
	logic signed [63:0]      px_sa, py_sa;
	wsp_tag_t                tag_sa;
	logic signed [63:0]      hx, hy;
	logic signed [COORD_W-1:0] sx, sy;
	logic                    vis;

	always_comb begin
		nx = tag_in.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
		ny = tag_in.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
	end

	always_comb begin
		hx = px_sa >>> 1;
		hy = py_sa >>> 1;
		sx = (hx > SMAX) ? COORD_W'(SMAX) : (hx < SMIN) ? COORD_W'(SMIN) : hx[COORD_W-1:0];
		sy = (hy > SMAX) ? COORD_W'(SMAX) : (hy < SMIN) ? COORD_W'(SMIN) : hy[COORD_W-1:0];
		vis = !sx[COORD_W-1] && (sx < $signed(COORD_W'({width, 16'h0})))
			&& !sy[COORD_W-1] && (sy < $signed(COORD_W'({height, 16'h0})));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sa <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			tag_sa <= tag_in;
			out_valid <= tag_sa.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_sa <= 64'(nx + ONE) * 64'($signed({1'b0, width}));
			py_sa <= 64'(ONE - ny) * 64'($signed({1'b0, height}));
			projected <= tag_sa.ok;
			screen_x <= tag_sa.ok ? sx : '0;
			screen_y <= tag_sa.ok ? sy : '0;
			visible <= tag_sa.ok && vis;
		end
	end

endmodule

// ===== hw/rtl/world_to_screen_projection.sv =====
// Top level: config registers, pipeline enable, clip/divide/screen stages.
// Depends on wsp_pkg, wsp_clip, wsp_div, wsp_screen.
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall  | world_x, world_y, world_z
//  output  | out_valid / out_stall| projected, screen_x, screen_y, visible
//  config  | cfg_wr_en            | cfg_index, cfg_data
//
// One item per cycle while the pipeline is not stalled; 3 clip stages, 47 divider stages
// (one quotient bit each), 2 viewport stages.
// Reset clears valid bits and loads the register defaults.
// A stall on a held result freezes the whole pipeline; in_stall follows it.
module world_to_screen_projection (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_x,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_y,
	input  logic signed [wsp_pkg::COORD_W-1:0] world_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              projected,
	output logic signed [wsp_pkg::COORD_W-1:0] screen_x,
	output logic signed [wsp_pkg::COORD_W-1:0] screen_y,
	output logic                              visible,
	input  logic                              cfg_wr_en,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsp_pkg::CFG_W-1:0]         cfg_data
);
	import wsp_pkg::*;

	logic [CFG_W-1:0]  row_lo_q [3];
	logic [CFG_W-1:0]  row_hi_q [3];
	logic [DIM_W-1:0]  width_q, height_q;
	logic              en;
	wsp_tag_t          tag_s3, tag_dv;
	logic [CLIP_W-1:0] mag_x_s3, mag_y_s3, den_s3;
	logic [NDC_W-1:0]  q_x, q_y;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_lo_q[0] <= 64'd65536;
			row_hi_q[0] <= '0;
			row_lo_q[1] <= 64'd281474976710656;
			row_hi_q[1] <= '0;
			row_lo_q[2] <= '0;
			row_hi_q[2] <= 64'd281474976710656;
			width_q <= '0;
			height_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_X_LO:   row_lo_q[0] <= cfg_data;
				REG_X_HI:   row_hi_q[0] <= cfg_data;
				REG_Y_LO:   row_lo_q[1] <= cfg_data;
				REG_Y_HI:   row_hi_q[1] <= cfg_data;
				REG_W_LO:   row_lo_q[2] <= cfg_data;
				REG_W_HI:   row_hi_q[2] <= cfg_data;
				REG_WIDTH:  width_q <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	wsp_clip u_clip (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.row_lo(row_lo_q), .row_hi(row_hi_q), .width(width_q), .height(height_q),
		.tag_s3(tag_s3), .mag_x_s3(mag_x_s3), .mag_y_s3(mag_y_s3), .den_s3(den_s3)
	);

	wsp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .tag_in(tag_s3),
		.mag_x(mag_x_s3), .mag_y(mag_y_s3), .den(den_s3),
		.tag_out(tag_dv), .q_x(q_x), .q_y(q_y)
	);

	wsp_screen u_screen (
		.clk(clk), .arst_n(arst_n), .en(en), .tag_in(tag_dv),
		.q_x(q_x), .q_y(q_y), .width(width_q), .height(height_q),
		.out_valid(out_valid), .projected(projected),
		.screen_x(screen_x), .screen_y(screen_y), .visible(visible)
	);

	a_unproj_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !projected) |-> (screen_x == '0 && screen_y == '0 && !visible))
		else $error("unprojected item carries nonzero coordinates");

	a_vis_proj: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && visible) |-> (projected && !screen_x[COORD_W-1] && !screen_y[COORD_W-1]))
		else $error("visible item outside projection");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (out_valid && $stable(tag_dv)))
		else $error("pipeline moved while frozen");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for world_to_screen_projection: drives world points,
// predicts pixel results in fixed point and compares them in order.
// Depends on wsp_pkg and the RTL of the projection pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wsp_pkg::*;

	localparam int LATENCY   = 52;
	localparam int MAX_CYCLE = 400000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct packed {
		logic               projected;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               visible;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic projected, visible;
	logic signed [31:0] screen_x, screen_y;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	world_to_screen_projection u_dut (.*);

	logic [63:0] matrix_regs [6];
	logic [13:0] vp_width, vp_height;
	point_t point_q [$];
	pixel_t pixel_q [$];
	int errors = 0;
	int cycle = 0;
	int burst_left = 0, gap_left = 0;
	logic took_item = 1'b0;

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int n);
		return v >>> n;
	endfunction

	function automatic logic signed [63:0] row_sum(logic [63:0] lo, logic [63:0] hi, point_t p);
		logic signed [63:0] acc;
		acc = floor_shr($signed(lo[31:0]) * 64'(p.x), 16);
		acc += floor_shr($signed(lo[63:32]) * 64'(p.y), 16);
		acc += floor_shr($signed(hi[31:0]) * 64'(p.z), 16);
		acc += 64'($signed(hi[63:32]));
		return acc;
	endfunction

	// the scaled dividend exceeds 64 bits, so the quotient is formed at 128 bits
	function automatic logic signed [63:0] ndc_quot(logic signed [63:0] num,
			logic signed [63:0] den);
		logic [63:0] mag, q;
		logic [127:0] wide;
		mag = num < 0 ? -num : num;
		if (mag / den >= 64'h8000_0000) begin
			q = 64'h8000_0000_0000;
		end else begin
			wide = (128'(mag) << 16) / 128'(den);
			q = wide[63:0];
		end
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic pixel_t project_point(point_t p);
		pixel_t r;
		logic signed [63:0] cx, cy, cw, nx, ny, sx, sy;
		r = '0;
		if (vp_width == 0 || vp_height == 0) return r;
		cw = row_sum(matrix_regs[REG_W_LO], matrix_regs[REG_W_HI], p);
		if (cw <= 0) return r;
		cx = row_sum(matrix_regs[REG_X_LO], matrix_regs[REG_X_HI], p);
		cy = row_sum(matrix_regs[REG_Y_LO], matrix_regs[REG_Y_HI], p);
		nx = ndc_quot(cx, cw);
		ny = ndc_quot(cy, cw);
		sx = clamp32(floor_shr((nx + 65536) * 64'(vp_width), 1));
		sy = clamp32(floor_shr((65536 - ny) * 64'(vp_height), 1));
		r.projected = 1'b1;
		r.sx = sx[31:0];
		r.sy = sy[31:0];
		r.visible = sx >= 0 && sx < 64'(vp_width) * 65536
			&& sy >= 0 && sy < 64'(vp_height) * 65536;
		return r;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx >= REG_WIDTH) begin
			if (idx == REG_WIDTH) vp_width = value[13:0];
			else vp_height = value[13:0];
		end else begin
			matrix_regs[idx] = value;
		end
	endtask

	task automatic drain();
		while (point_q.size() != 0 || in_valid || pixel_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0001_0000;
			2: return 32'h0;
			default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
		endcase
	endfunction

	task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.x = x; p.y = y; p.z = z;
		point_q.push_back(p);
	endtask

	// feeder: bursts of items with random gaps
	always @(negedge clk) begin
		point_t p;
		if (arst_n) begin
			if (!in_valid || took_item) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (point_q.size() > 0) begin
					p = point_q.pop_front();
					world_x <= p.x; world_y <= p.y; world_z <= p.z;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver stall pattern: long clean runs, then random stalling
			out_stall <= ((cycle >> 8) & 1) ? ($urandom_range(0, 3) == 0) : 1'b0;
		end
	end

	always @(posedge clk) begin
		took_item <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			pixel_q.push_back(project_point({world_x, world_y, world_z}));
		if (out_valid && !out_stall) begin
			pixel_t e;
			if (pixel_q.size() == 0) begin
				$error("result with no item pending");
				errors++;
			end else begin
				e = pixel_q.pop_front();
				if (projected !== e.projected) begin
					$error("projected exp %0d got %0d", e.projected, projected);
					errors++;
				end
				if (screen_x !== e.sx) begin
					$error("screen_x exp %0d got %0d", e.sx, screen_x);
					errors++;
				end
				if (screen_y !== e.sy) begin
					$error("screen_y exp %0d got %0d", e.sy, screen_y);
					errors++;
				end
				if (visible !== e.visible) begin
					$error("visible exp %0d got %0d", e.visible, visible);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		matrix_regs[REG_X_LO] = 64'd65536;
		matrix_regs[REG_X_HI] = 64'd0;
		matrix_regs[REG_Y_LO] = 64'd281474976710656;
		matrix_regs[REG_Y_HI] = 64'd0;
		matrix_regs[REG_W_LO] = 64'd0;
		matrix_regs[REG_W_HI] = 64'd281474976710656;
		vp_width = '0;
		vp_height = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero viewport with reset matrix
		queue_point(32'h0001_0000, 32'h0, 32'h0);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		drain();

		write_reg(REG_WIDTH, 64'd640);
		write_reg(REG_HEIGHT, 64'hFFFF_FFFF_FFFF_C1E0);
		queue_point(32'h0, 32'h0, 32'h0);
		queue_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
		queue_point(32'h0000_FFFF, 32'hFFFF_0001, 32'hAAAA_5555);
		drain();

		// w row depends on z: points behind and at the camera plane
		write_reg(REG_W_LO, 64'h0);
		write_reg(REG_W_HI, 64'h0000_0000_0001_0000);
		write_reg(REG_X_HI, 64'h0002_0000_0000_8000);
		write_reg(REG_Y_HI, 64'hFFFF_0000_FFFF_8000);
		queue_point(32'h0001_0000, 32'h0001_0000, 32'h0);
		queue_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
		queue_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();

		// extreme viewport and random matrices
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_WIDTH, phase == 0 ? 64'd16383 : 64'($urandom_range(1, 2000)));
			write_reg(REG_HEIGHT, phase == 0 ? 64'd16383 : 64'($urandom_range(1, 2000)));
			if (phase == 5) write_reg(REG_HEIGHT, 64'd0);
			for (int r = 0; r < 6; r++) begin
				logic [63:0] v;
				v = {rand_coef(), rand_coef()};
				if (r == REG_W_HI && $urandom_range(0, 1)) v[63:32] = 32'h0004_0000;
				write_reg(reg_idx_t'(r), v);
			end
			n = phase == 0 ? 60 : 180;
			for (int i = 0; i < n; i++)
				queue_point(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0 && pixel_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
